### design/fbfl_pkg.sv
// Package: types, constants and codes for the fixed-block free-list allocator.
`timescale 1ns / 1ps

package fbfl_pkg;

    localparam int MAX_UNITS_DEF = 256;

    localparam int UNIT_W       = 8;
    localparam int OFFSET_W     = 20;
    localparam int UNIT_COUNT_W = 9;
    localparam int UNIT_BYTES_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [UNIT_COUNT_W-1:0] UNIT_COUNT_RST = 9'd256;
    localparam logic [UNIT_BYTES_W-1:0] UNIT_BYTES_RST = 13'd64;
    localparam logic [UNIT_BYTES_W-1:0] UNIT_BYTES_MIN = 13'd8;
    localparam logic [UNIT_BYTES_W-1:0] UNIT_BYTES_MAX = 13'd4096;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_INIT
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [UNIT_W-1:0] freed_unit;
    } t_in_item;

    typedef struct packed {
        logic                granted;
        logic [UNIT_W-1:0]   granted_unit;
        logic [OFFSET_W-1:0] granted_offset;
        logic                pool_empty;
    } t_out_item;

endpackage

### design/fbfl_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/fixed_block_free_list_allocator_top.sv
// Top level: fixed-size block allocator with a LIFO free list held in a link RAM.
`timescale 1ns / 1ps
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one operation per
// transaction: initialize the pool, allocate a unit, or free a unit. Every
// operation returns exactly one result transaction on the output channel
// (o_out_valid / i_out_ready / o_out_data): grant flag, unit index, byte offset
// (index times unit size) and whether the pool is empty afterwards.
// The config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// sets unit count and unit size and is always ready; the user must write it
// only while idle; the block does not enforce this. Free, unused opcodes and
// allocate on an empty pool are answered from idle; allocate waits in ST_ALLOC
// for the registered link RAM read; initialize writes one link per unit.
// The result sits in an output register; a new operation is accepted while
// the previous result is being taken, and the block holds off when the
// receiver stalls with a result pending.
// Reset: head becomes null (pool empty), unit count 256, unit size 64 bytes.
// The link RAM is not cleared; an initialize or free writes each link before use.

module fixed_block_free_list_allocator_top #(
    parameter int MAX_UNITS = fbfl_pkg::MAX_UNITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fbfl_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fbfl_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_UNITS);
    localparam int LINK_W = $clog2(MAX_UNITS + 1);
    localparam int CMP_W  = (LINK_W > fbfl_pkg::UNIT_COUNT_W) ? LINK_W
                                                              : fbfl_pkg::UNIT_COUNT_W;
    localparam int PROD_W = (LINK_W + fbfl_pkg::UNIT_BYTES_W > fbfl_pkg::OFFSET_W)
                          ? LINK_W + fbfl_pkg::UNIT_BYTES_W : fbfl_pkg::OFFSET_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_UNITS);
    localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_UNITS);

    fbfl_pkg::t_state                     r_state, n_state;
    logic [LINK_W-1:0]                    r_head, n_head;
    logic [IDX_W-1:0]                     r_idx, n_idx;
    logic [fbfl_pkg::UNIT_COUNT_W-1:0]    r_unit_count;
    logic [fbfl_pkg::UNIT_BYTES_W-1:0]    r_unit_bytes;
    logic                                 r_out_valid, n_out_valid;
    fbfl_pkg::t_out_item                  r_out, n_out;

    logic                                 out_free;
    logic                                 in_fire;
    logic                                 head_null;
    logic [CMP_W-1:0]                     unit_ext;
    logic                                 unit_ok;
    logic [CMP_W-1:0]                     cnt_ext;
    logic [CMP_W-1:0]                     last_idx;
    logic                                 idx_last;
    logic [CMP_W-1:0]                     head_ext;
    logic [fbfl_pkg::UNIT_BYTES_W-1:0]    eff_bytes;
    logic [PROD_W-1:0]                    prod;

    logic                                 ram_we;
    logic [IDX_W-1:0]                     ram_waddr;
    logic [LINK_W-1:0]                    ram_wdata;
    logic                                 ram_re;
    logic [IDX_W-1:0]                     ram_raddr;
    logic [LINK_W-1:0]                    ram_rdata;

    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_UNITS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == fbfl_pkg::ST_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign head_null = (r_head >= NULL_LINK);
    assign unit_ext  = CMP_W'(i_in_data.freed_unit);
    assign unit_ok   = (unit_ext < MAX_CMP);
    assign head_ext  = CMP_W'(r_head);

    always_comb begin
        cnt_ext = CMP_W'(r_unit_count);
        if (cnt_ext == '0) begin
            last_idx = '0;
        end else if (cnt_ext > MAX_CMP) begin
            last_idx = MAX_CMP - CMP_W'(1);
        end else begin
            last_idx = cnt_ext - CMP_W'(1);
        end
    end

    assign idx_last = (CMP_W'(r_idx) == last_idx);

    always_comb begin
        if (r_unit_bytes < fbfl_pkg::UNIT_BYTES_MIN) begin
            eff_bytes = fbfl_pkg::UNIT_BYTES_MIN;
        end else if (r_unit_bytes > fbfl_pkg::UNIT_BYTES_MAX) begin
            eff_bytes = fbfl_pkg::UNIT_BYTES_MAX;
        end else begin
            eff_bytes = r_unit_bytes;
        end
    end

    assign prod = PROD_W'(r_head) * PROD_W'(eff_bytes);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = r_head;
        ram_re      = 1'b0;
        ram_raddr   = r_head[IDX_W-1:0];

        case (r_state)
            fbfl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_out            = '0;
                    n_out.pool_empty = head_null;
                    case (i_in_data.opcode)
                        fbfl_pkg::OP_INIT: begin
                            n_idx   = '0;
                            n_state = fbfl_pkg::ST_INIT;
                        end
                        fbfl_pkg::OP_ALLOC: begin
                            if (head_null) begin
                                n_out_valid = 1'b1;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = fbfl_pkg::ST_ALLOC;
                            end
                        end
                        fbfl_pkg::OP_FREE: begin
                            n_out_valid = 1'b1;
                            if (unit_ok) begin
                                ram_we           = 1'b1;
                                ram_waddr        = unit_ext[IDX_W-1:0];
                                ram_wdata        = r_head;
                                n_head           = unit_ext[LINK_W-1:0];
                                n_out.pool_empty = 1'b0;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            fbfl_pkg::ST_ALLOC: begin
                if (out_free) begin
                    n_out.granted        = 1'b1;
                    n_out.granted_unit   = head_ext[fbfl_pkg::UNIT_W-1:0];
                    n_out.granted_offset = prod[fbfl_pkg::OFFSET_W-1:0];
                    n_out.pool_empty     = (ram_rdata >= NULL_LINK);
                    n_out_valid          = 1'b1;
                    n_head               = ram_rdata;
                    n_state              = fbfl_pkg::ST_IDLE;
                end
            end
            fbfl_pkg::ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = idx_last ? NULL_LINK : LINK_W'(r_idx) + LINK_W'(1);
                if (!idx_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end else if (out_free) begin
                    n_head      = '0;
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_state     = fbfl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fbfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fbfl_pkg::ST_IDLE;
            r_head       <= NULL_LINK;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_unit_count <= fbfl_pkg::UNIT_COUNT_RST;
            r_unit_bytes <= fbfl_pkg::UNIT_BYTES_RST;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fbfl_pkg::CFG_UNIT_COUNT: begin
                        r_unit_count <= i_cfg_data[fbfl_pkg::UNIT_COUNT_W-1:0];
                    end
                    fbfl_pkg::CFG_UNIT_BYTES: begin
                        r_unit_bytes <= i_cfg_data[fbfl_pkg::UNIT_BYTES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_out_valid || i_out_ready))
        else $error("operation accepted while result register blocked");

    a_alloc_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbfl_pkg::ST_ALLOC) |-> !head_null)
        else $error("allocate read issued with null head");

    a_free_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_data.opcode == fbfl_pkg::OP_FREE) && unit_ok)
        |=> (r_head == $past(unit_ext[LINK_W-1:0])))
        else $error("free did not push unit onto head");

    a_init_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbfl_pkg::ST_INIT) ##1 (r_state == fbfl_pkg::ST_IDLE)
        |-> (r_head == '0))
        else $error("initialize finished without head at unit zero");

    a_grant_not_empty_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbfl_pkg::ST_ALLOC) && out_free |=> (r_out_valid && r_out.granted))
        else $error("allocate completion did not produce a grant");

endmodule

### tb/fixed_block_free_list_allocator_top_test.sv
// Self-checking testbench for the fixed-block free-list allocator: directed table, then random phases.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_top_test;

    localparam int MAX_UNITS = fbfl_pkg::MAX_UNITS_DEF;
    localparam logic [8:0] NULL_LINK = 9'd256;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [fbfl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [fbfl_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 300;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int NUM_DIRECTED = 19;

    typedef struct packed {
        fbfl_pkg::t_in_item  op;
        logic                known;
        fbfl_pkg::t_out_item result;
    } t_dir_row;

    // after reset: 256 units of 64 bytes, list empty
    localparam t_dir_row DIRECTED_OPS [NUM_DIRECTED] = '{
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b1, '{1'b0, 8'd0,   20'd0,     1'b1}},
        '{'{OP_NONE,            8'd0},   1'b1, '{1'b0, 8'd0,   20'd0,     1'b1}},
        '{'{fbfl_pkg::OP_FREE,  8'd255}, 1'b1, '{1'b0, 8'd0,   20'd0,     1'b0}},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b1, '{1'b1, 8'd255, 20'd16320, 1'b1}},
        '{'{fbfl_pkg::OP_FREE,  8'd0},   1'b1, '{1'b0, 8'd0,   20'd0,     1'b0}},
        '{'{fbfl_pkg::OP_FREE,  8'd0},   1'b1, '{1'b0, 8'd0,   20'd0,     1'b0}},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b0, '0},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b0, '0},
        '{'{fbfl_pkg::OP_INIT,  8'd0},   1'b1, '{1'b0, 8'd0,   20'd0,     1'b0}},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b1, '{1'b1, 8'd0,   20'd0,     1'b0}},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b1, '{1'b1, 8'd1,   20'd64,    1'b0}},
        '{'{fbfl_pkg::OP_FREE,  8'hAA},  1'b1, '{1'b0, 8'd0,   20'd0,     1'b0}},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b1, '{1'b1, 8'd170, 20'd10880, 1'b0}},
        '{'{fbfl_pkg::OP_FREE,  8'h55},  1'b0, '0},
        '{'{OP_NONE,            8'hFF},  1'b0, '0},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b0, '0},
        '{'{fbfl_pkg::OP_ALLOC, 8'd0},   1'b0, '0},
        '{'{fbfl_pkg::OP_FREE,  8'd1},   1'b0, '0},
        '{'{fbfl_pkg::OP_INIT,  8'd0},   1'b0, '0}
    };

    localparam logic [fbfl_pkg::CFG_DATA_W-1:0] PHASE_COUNT [NUM_PHASES] = '{
        13'd1, 13'd0, 13'd256, 13'h1FFF, 13'd3, 13'd12, 13'd40, 13'd257, 13'd2, 13'd100
    };
    localparam logic [fbfl_pkg::CFG_DATA_W-1:0] PHASE_BYTES [NUM_PHASES] = '{
        13'd8, 13'd0, 13'd4096, 13'h1FFF, 13'd7, 13'd100, 13'd4095, 13'd9, 13'h0AAA, 13'h1555
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    fbfl_pkg::t_in_item              i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    fbfl_pkg::t_out_item             o_out_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [fbfl_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [fbfl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fixed_block_free_list_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow pool
    logic [8:0]                        link_mem [MAX_UNITS];
    logic [8:0]                        head_unit = NULL_LINK;
    logic [fbfl_pkg::UNIT_COUNT_W-1:0] unit_count_reg = fbfl_pkg::UNIT_COUNT_RST;
    logic [fbfl_pkg::UNIT_BYTES_W-1:0] unit_bytes_reg = fbfl_pkg::UNIT_BYTES_RST;

    fbfl_pkg::t_out_item               expected_results [$];
    logic [fbfl_pkg::UNIT_W-1:0]       units_on_loan [$];
    fbfl_pkg::t_out_item               oldest_result;
    int                                fail_count = 0;
    int                                quiet_cycles = 0;
    bit                                tx_idle_on = 1'b1;
    bit                                rx_stall_on = 1'b1;

    function automatic fbfl_pkg::t_out_item predict_pool_op(input fbfl_pkg::t_in_item op);
        fbfl_pkg::t_out_item res;
        int          n;
        int          bytes;
        logic [31:0] offset;
        res = '0;
        case (op.opcode)
            fbfl_pkg::OP_INIT: begin
                n = (unit_count_reg < 1) ? 1 :
                    (unit_count_reg > MAX_UNITS) ? MAX_UNITS : int'(unit_count_reg);
                for (int i = 0; i + 1 < n; i++) link_mem[i] = 9'(i + 1);
                link_mem[n-1] = NULL_LINK;
                head_unit = 9'd0;
                units_on_loan.delete();
            end
            fbfl_pkg::OP_ALLOC: begin
                if (head_unit < NULL_LINK) begin
                    bytes = (unit_bytes_reg < fbfl_pkg::UNIT_BYTES_MIN)
                            ? int'(fbfl_pkg::UNIT_BYTES_MIN) :
                            (unit_bytes_reg > fbfl_pkg::UNIT_BYTES_MAX)
                            ? int'(fbfl_pkg::UNIT_BYTES_MAX) :
                            int'(unit_bytes_reg);
                    offset = 32'(head_unit) * 32'(bytes);
                    res.granted = 1'b1;
                    res.granted_unit = head_unit[7:0];
                    res.granted_offset = offset[fbfl_pkg::OFFSET_W-1:0];
                    units_on_loan.push_back(head_unit[7:0]);
                    head_unit = link_mem[head_unit];
                end
            end
            fbfl_pkg::OP_FREE: begin
                link_mem[op.freed_unit] = head_unit;
                head_unit = {1'b0, op.freed_unit};
            end
            default: ;
        endcase
        res.pool_empty = (head_unit >= NULL_LINK);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [19:0] exp_val,
                                        input logic [19:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endfunction

    task automatic issue_op(input fbfl_pkg::t_in_item op, input logic known,
                            input fbfl_pkg::t_out_item known_res);
        int                  gap;
        fbfl_pkg::t_out_item res;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= op;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        res = predict_pool_op(op);
        expected_results.push_back(known ? known_res : res);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [fbfl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbfl_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx == fbfl_pkg::CFG_UNIT_COUNT)
            unit_count_reg = value[fbfl_pkg::UNIT_COUNT_W-1:0];
        else if (idx == fbfl_pkg::CFG_UNIT_BYTES)
            unit_bytes_reg = value[fbfl_pkg::UNIT_BYTES_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // result receiver with random back-pressure
    initial begin
        int stall;
        int taken;
        taken = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = rx_stall_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
            taken++;
            if (taken % 32 == 0) rx_stall_on = ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction: expected none, actual %h",
                         $time, o_out_data);
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("granted", 20'(oldest_result.granted), 20'(o_out_data.granted));
                check_field("granted_unit", 20'(oldest_result.granted_unit),
                            20'(o_out_data.granted_unit));
                check_field("granted_offset", oldest_result.granted_offset,
                            o_out_data.granted_offset);
                check_field("pool_empty", 20'(oldest_result.pool_empty),
                            20'(o_out_data.pool_empty));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout, %0d results outstanding", $time,
                     expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        fbfl_pkg::t_in_item op;
        int                 roll;
        int                 alloc_pct;
        int                 pick;
        alloc_pct = 50;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
            issue_op(DIRECTED_OPS[r].op, DIRECTED_OPS[r].known, DIRECTED_OPS[r].result);

        for (int p = 0; p < NUM_PHASES; p++) begin
            i_in_valid <= 1'b0;
            while (expected_results.size() != 0) @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            write_cfg(fbfl_pkg::CFG_UNIT_COUNT, PHASE_COUNT[p]);
            write_cfg(fbfl_pkg::CFG_UNIT_BYTES, PHASE_BYTES[p]);
            write_cfg((p % 2 == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, 13'($urandom));
            op.opcode = fbfl_pkg::OP_INIT;
            op.freed_unit = 8'($urandom);
            issue_op(op, 1'b0, '0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 30 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    alloc_pct = $urandom_range(25, 70);
                end
                roll = $urandom_range(0, 99);
                op.freed_unit = 8'($urandom_range(0, 255));
                if (roll < 2) begin
                    op.opcode = fbfl_pkg::OP_INIT;
                end else if (roll < 4) begin
                    op.opcode = OP_NONE;
                end else if (roll < 4 + alloc_pct) begin
                    op.opcode = fbfl_pkg::OP_ALLOC;
                end else begin
                    op.opcode = fbfl_pkg::OP_FREE;
                    // mostly hand back a unit actually held; otherwise any index
                    if (units_on_loan.size() != 0 && $urandom_range(0, 3) != 0) begin
                        pick = $urandom_range(0, units_on_loan.size() - 1);
                        op.freed_unit = units_on_loan[pick];
                        units_on_loan.delete(pick);
                    end
                end
                issue_op(op, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### fixed_block_free_list_allocator_top.f
design/fbfl_pkg.sv
design/fbfl_ram.sv
design/fixed_block_free_list_allocator_top.sv
tb/fixed_block_free_list_allocator_top_test.sv
